// ===== design/ublm_pkg.sv =====
// shared command codes and lane count of the unaligned byte lane memory
package ublm_pkg;

  // access commands as carried on the input tuser
  typedef enum logic [2:0] {
    CMD_LOAD_WORD  = 3'd0,
    CMD_LOAD_HALF  = 3'd1,
    CMD_LOAD_BYTE  = 3'd2,
    CMD_STORE_WORD = 3'd3,
    CMD_STORE_HALF = 3'd4,
    CMD_STORE_BYTE = 3'd5
  } cmd_e;

  // number of byte lanes the storage is split into
  localparam int unsigned LANES = 4;

endpackage

// ===== design/unaligned_byte_lane_memory.sv =====
// big-endian byte-addressed load/store memory over four byte-lane banks
//
// Byte-addressed, big-endian memory holding STORE_HALFWORDS halfwords. Each input
// transaction is a word, halfword or byte load or store at any byte address; every
// transaction returns one output transaction: the load data zero-extended to 32 bits,
// or zero for stores and unused command codes. Storage is split into four byte-lane
// banks (byte address modulo 4), so any access of up to four consecutive bytes touches
// each bank at most once and a store only writes its own bytes. A transaction passes
// through the synchronous bank read or write, then the result is assembled into the
// output register; a new transaction is taken only once the previous result has reached
// the output register and the output side keeps up. After reset the banks are cleared
// row by row, and tready stays low until done.
module unaligned_byte_lane_memory #(
  parameter int unsigned STORE_HALFWORDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // byte_address [7:0], write_value [39:8]
  input  logic [2:0]  s_axis_tuser,   // command [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // read_value [31:0]
);

  localparam int unsigned ROWS  = (STORE_HALFWORDS + 1) / 2;
  localparam int unsigned ROW_W = $clog2(ROWS);

  // input fields
  ublm_pkg::cmd_e cmd;
  logic [7:0]     addr;
  logic [31:0]    wval;
  logic           s_fire;
  logic           is_store;
  logic [2:0]     nbytes;

  // control state
  logic             clearing_q;
  logic [ROW_W-1:0] clr_row_q;
  logic             pend_q;
  logic             out_valid_q;

  // payload registers
  ublm_pkg::cmd_e cmd_q;
  logic [1:0]     off_q;
  logic [31:0]    out_data_q;
  logic [31:0]    result;

  // per-lane access signals
  logic [1:0]       lane_off   [ublm_pkg::LANES];
  logic [8:0]       lane_baddr [ublm_pkg::LANES];
  logic [ROW_W-1:0] lane_row   [ublm_pkg::LANES];
  logic [1:0]       lane_shift [ublm_pkg::LANES];
  logic [31:0]      lane_shv   [ublm_pkg::LANES];
  logic [ublm_pkg::LANES-1:0] mem_we;
  logic [ROW_W-1:0] mem_row    [ublm_pkg::LANES];
  logic [7:0]       mem_wdata  [ublm_pkg::LANES];
  logic [7:0]       lane_rd_q  [ublm_pkg::LANES];
  logic [7:0]       rd_byte    [ublm_pkg::LANES];

  assign cmd  = ublm_pkg::cmd_e'(s_axis_tuser);
  assign addr = s_axis_tdata[7:0];
  assign wval = s_axis_tdata[39:8];

  // one transaction in flight, output slot free by the time the result lands
  assign s_axis_tready = !clearing_q && !pend_q && (!out_valid_q || m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // store width in bytes
  always_comb begin
    is_store = 1'b0;
    nbytes   = 3'd0;
    unique case (cmd)
      ublm_pkg::CMD_STORE_WORD: begin
        is_store = 1'b1;
        nbytes   = 3'd4;
      end
      ublm_pkg::CMD_STORE_HALF: begin
        is_store = 1'b1;
        nbytes   = 3'd2;
      end
      ublm_pkg::CMD_STORE_BYTE: begin
        is_store = 1'b1;
        nbytes   = 3'd1;
      end
      default: begin
        is_store = 1'b0;
        nbytes   = 3'd0;
      end
    endcase
  end

  // lane addressing: lane j holds byte k of the access where k = (j - addr) mod 4
  always_comb begin
    for (int j = 0; j < ublm_pkg::LANES; j++) begin
      lane_off[j]   = 2'(j) - addr[1:0];
      lane_baddr[j] = {1'b0, addr} + {7'b0, lane_off[j]};
      lane_row[j]   = ROW_W'(lane_baddr[j][8:2]);
      lane_shift[j] = 2'(nbytes - 3'd1 - {1'b0, lane_off[j]});
      lane_shv[j]   = wval >> {lane_shift[j], 3'b000};
      if (clearing_q) begin
        mem_we[j]    = 1'b1;
        mem_row[j]   = clr_row_q;
        mem_wdata[j] = 8'h00;
      end else begin
        mem_we[j]    = s_fire && is_store && ({1'b0, lane_off[j]} < nbytes);
        mem_row[j]   = lane_row[j];
        mem_wdata[j] = lane_shv[j][7:0];
      end
    end
  end

  // byte-lane banks with registered read
  for (genvar j = 0; j < ublm_pkg::LANES; j++) begin : g_lane
    logic [7:0] mem [ROWS];

    always_ff @(posedge clk_i) begin
      if (mem_we[j]) begin
        mem[mem_row[j]] <= mem_wdata[j];
      end
      lane_rd_q[j] <= mem[lane_row[j]];
    end
  end

  // pick bytes in access order and assemble the big-endian result
  always_comb begin
    for (int k = 0; k < ublm_pkg::LANES; k++) begin
      rd_byte[k] = lane_rd_q[2'(off_q + 2'(k))];
    end
    unique case (cmd_q)
      ublm_pkg::CMD_LOAD_WORD: result = {rd_byte[0], rd_byte[1], rd_byte[2], rd_byte[3]};
      ublm_pkg::CMD_LOAD_HALF: result = {16'h0000, rd_byte[0], rd_byte[1]};
      ublm_pkg::CMD_LOAD_BYTE: result = {24'h000000, rd_byte[0]};
      default:                 result = 32'h0000_0000;
    endcase
  end

  // control: clearing pass, pending access, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_row_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        if (clr_row_q == ROW_W'(ROWS - 1)) begin
          clearing_q <= 1'b0;
        end else begin
          clr_row_q <= clr_row_q + ROW_W'(1);
        end
      end
      pend_q <= s_fire;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q <= cmd;
      off_q <= addr[1:0];
    end
    if (pend_q) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/ublm_checker.sv =====
// port-level checks of the unaligned byte lane memory and their binding
module ublm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic s_fire;
  logic s_is_load;
  logic s_is_narrow;

  assign s_fire      = s_axis_tvalid && s_axis_tready;
  assign s_is_load   = (s_axis_tuser == ublm_pkg::CMD_LOAD_WORD) ||
                       (s_axis_tuser == ublm_pkg::CMD_LOAD_HALF) ||
                       (s_axis_tuser == ublm_pkg::CMD_LOAD_BYTE);
  assign s_is_narrow = (s_axis_tuser == ublm_pkg::CMD_LOAD_HALF) ||
                       (s_axis_tuser == ublm_pkg::CMD_LOAD_BYTE);

  // one transaction at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("input accepted while a transaction is in flight");

  // fixed latency to the output register
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> ##2 m_axis_tvalid)
    else $error("result not presented two cycles after acceptance");

  // stores and unused codes return zero
  a_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !s_is_load |-> ##2 (m_axis_tdata == 32'h0000_0000))
    else $error("non-load transaction returned non-zero data");

  // narrow loads are zero-extended
  a_narrow_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_is_narrow |-> ##2 (m_axis_tdata[31:16] == 16'h0000))
    else $error("narrow load not zero-extended");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

endmodule

bind unaligned_byte_lane_memory ublm_checker u_ublm_checker (.*);

// ===== sim/unaligned_byte_lane_memory_test.sv =====
// self-checking testbench for the unaligned byte lane memory
`timescale 1ns / 100ps

module unaligned_byte_lane_memory_test;

  localparam int unsigned HALFWORDS    = 256;
  localparam int unsigned RANDOM_ITEMS = 1450;
  // slowest legal run: ~1500 items, each with the longest send gap and receive stall
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]  command;
    logic [7:0]  byte_address;
    logic [31:0] write_value;
    bit          wait_idle;
  } access_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // byte_address [7:0], write_value [39:8]
  logic [2:0]  s_axis_tuser = '0;   // command [2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // read_value [31:0]

  // shadow copy of the halfword storage
  logic [15:0] shadow_mem [HALFWORDS];

  access_t     pending_accesses[$];
  logic [31:0] expected_reads[$];
  access_t     in_flight;

  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_stall = 0;
  int unsigned recv_calm = 0;
  int unsigned cycles = 0;
  int unsigned failures = 0;
  int unsigned results_seen = 0;
  int unsigned load_count = 0;
  int unsigned store_count = 0;
  int unsigned spare_count = 0;
  int unsigned odd_count = 0;

  unaligned_byte_lane_memory #(
    .STORE_HALFWORDS(HALFWORDS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // byte b sits in halfword b/2, high byte when even
  function automatic logic [7:0] byte_at(logic [8:0] b);
    logic [15:0] h;
    h = shadow_mem[(b >> 1) % HALFWORDS];
    return b[0] ? h[7:0] : h[15:8];
  endfunction

  function automatic void put_byte(logic [8:0] b, logic [7:0] v);
    int unsigned slot;
    slot = (b >> 1) % HALFWORDS;
    if (b[0]) shadow_mem[slot][7:0] = v;
    else shadow_mem[slot][15:8] = v;
  endfunction

  // big-endian access of 1, 2 or 4 bytes; returns the load data, zero for stores and spare codes
  function automatic logic [31:0] perform_access(access_t a);
    logic [31:0] rd;
    logic [8:0]  b;
    int unsigned n;
    bit          is_store;
    rd = '0;
    n = 0;
    is_store = 1'b0;
    case (a.command)
      ublm_pkg::CMD_LOAD_WORD:  n = 4;
      ublm_pkg::CMD_LOAD_HALF:  n = 2;
      ublm_pkg::CMD_LOAD_BYTE:  n = 1;
      ublm_pkg::CMD_STORE_WORD: begin n = 4; is_store = 1'b1; end
      ublm_pkg::CMD_STORE_HALF: begin n = 2; is_store = 1'b1; end
      ublm_pkg::CMD_STORE_BYTE: begin n = 1; is_store = 1'b1; end
      default:                  n = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      b = {1'b0, a.byte_address} + 9'(k);
      if (is_store) put_byte(b, a.write_value[8 * (n - 1 - k) +: 8]);
      else rd = {rd[23:0], byte_at(b)};
    end
    return rd;
  endfunction

  // idle lengths: mostly none or short, a few long, and quiet stretches now and then
  function automatic int unsigned draw_pause(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_access(logic [2:0] cmd, logic [7:0] addr, logic [31:0] value,
                            bit wait_idle = 1'b0);
    access_t a;
    a.command = cmd;
    a.byte_address = addr;
    a.write_value = value;
    a.wait_idle = wait_idle;
    pending_accesses.push_back(a);
  endtask

  function automatic void report_failure(string what, logic [31:0] exp, logic [31:0] act);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("%0t: %s: expected %08h, got %08h", $realtime, what, exp, act);
  endfunction

  // driver: presents queued accesses, predicts each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reads.push_back(perform_access(in_flight));
        case (in_flight.command)
          ublm_pkg::CMD_LOAD_WORD, ublm_pkg::CMD_LOAD_HALF,
          ublm_pkg::CMD_LOAD_BYTE:  load_count++;
          ublm_pkg::CMD_STORE_WORD, ublm_pkg::CMD_STORE_HALF,
          ublm_pkg::CMD_STORE_BYTE: store_count++;
          default:                  spare_count++;
        endcase
        if (in_flight.byte_address[0]) odd_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_accesses.size() > 0 &&
                     (!pending_accesses[0].wait_idle || expected_reads.size() == 0)) begin
          in_flight = pending_accesses.pop_front();
          s_axis_tdata  <= {in_flight.write_value, in_flight.byte_address};
          s_axis_tuser  <= in_flight.command;
          s_axis_tvalid <= 1'b1;
          send_gap = draw_pause(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_stall = draw_pause(recv_calm);
    end
  end

  // monitor: every output transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_reads.size() == 0) report_failure("result with none pending", '0, m_axis_tdata);
      else if (expected_reads[0] !== m_axis_tdata)
        report_failure("read_value mismatch", expected_reads.pop_front(), m_axis_tdata);
      else void'(expected_reads.pop_front());
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               expected_reads.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned hot_base;
    int unsigned roll;
    logic [2:0]  cmd;
    logic [7:0]  addr;
    logic [31:0] value;

    foreach (shadow_mem[i]) shadow_mem[i] = '0;

    // directed: empty reads, accesses past the top address, odd merges, spare codes
    add_access(ublm_pkg::CMD_LOAD_WORD,  8'd0,   32'h0);
    add_access(ublm_pkg::CMD_LOAD_WORD,  8'd255, 32'h0);
    add_access(ublm_pkg::CMD_STORE_WORD, 8'd255, 32'h1122_3344);
    add_access(ublm_pkg::CMD_LOAD_WORD,  8'd255, 32'h0);
    add_access(ublm_pkg::CMD_LOAD_HALF,  8'd254, 32'h0);
    add_access(ublm_pkg::CMD_STORE_HALF, 8'd1,   32'hffff_abcd);
    add_access(ublm_pkg::CMD_STORE_BYTE, 8'd0,   32'hffff_ffff);
    add_access(ublm_pkg::CMD_LOAD_WORD,  8'd0,   32'h0);
    add_access(ublm_pkg::CMD_STORE_WORD, 8'd4,   32'hffff_ffff);
    add_access(ublm_pkg::CMD_STORE_BYTE, 8'd5,   32'h0);
    add_access(ublm_pkg::CMD_LOAD_WORD,  8'd3,   32'hffff_ffff);
    add_access(ublm_pkg::CMD_LOAD_HALF,  8'd5,   32'h0);
    add_access(ublm_pkg::CMD_LOAD_BYTE,  8'd7,   32'h0);
    add_access(ublm_pkg::CMD_STORE_WORD, 8'd128, 32'ha5a5_a5a5);
    add_access(ublm_pkg::CMD_LOAD_WORD,  8'd127, 32'h0);
    add_access(CMD_SPARE_6,              8'd0,   32'hffff_ffff);
    add_access(CMD_SPARE_7,              8'd255, 32'hffff_ffff);
    add_access(ublm_pkg::CMD_LOAD_WORD,  8'd0,   32'h0);
    add_access(ublm_pkg::CMD_STORE_HALF, 8'd255, 32'h0000_beef);
    add_access(ublm_pkg::CMD_LOAD_WORD,  8'd253, 32'h0);
    add_access(ublm_pkg::CMD_STORE_BYTE, 8'd255, 32'h0000_0012);
    add_access(ublm_pkg::CMD_LOAD_HALF,  8'd255, 32'h0);
    add_access(ublm_pkg::CMD_LOAD_BYTE,  8'd255, 32'h0);
    add_access(ublm_pkg::CMD_LOAD_WORD,  8'd254, 32'h0);

    // random: mixed loads, stores and spare codes, clustered around a moving hot spot
    hot_base = $urandom_range(0, 255);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        case ($urandom_range(0, 2))
          0:       cmd = ublm_pkg::CMD_LOAD_WORD;
          1:       cmd = ublm_pkg::CMD_LOAD_HALF;
          default: cmd = ublm_pkg::CMD_LOAD_BYTE;
        endcase
      end else if (roll < 95) begin
        case ($urandom_range(0, 2))
          0:       cmd = ublm_pkg::CMD_STORE_WORD;
          1:       cmd = ublm_pkg::CMD_STORE_HALF;
          default: cmd = ublm_pkg::CMD_STORE_BYTE;
        endcase
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
      end
      if ($urandom_range(0, 19) == 0) hot_base = $urandom_range(0, 255);
      roll = $urandom_range(0, 99);
      if (roll < 20) addr = $urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                                                 : 8'($urandom_range(248, 255));
      else if (roll < 60) addr = 8'(hot_base + $urandom_range(0, 7));
      else addr = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 8) value = 32'h0;
      else if (roll < 16) value = 32'hffff_ffff;
      else value = $urandom;
      add_access(cmd, addr, value, (i % 500) == 250);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_accesses.size() > 0 || s_axis_tvalid || expected_reads.size() > 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d loads, %0d stores and %0d spare codes, %0d at odd addresses",
             load_count, store_count, spare_count, odd_count);
    $display("%0d results checked in %0d cycles, %0d failures", results_seen, cycles, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
